### hw/rtl/dcfst_pkg.sv
// Shared types, constants and tap weights for the dual channel FIR slope tracker.
// No dependencies; every other file in hw/rtl refers to this package by scoped names.
package dcfst_pkg;

	// Channel count default for the top level parameter
	localparam int CHANNELS_DEF = 2;

	// Filter geometry
	localparam int TAPS      = 16;
	localparam int TAP_IDX_W = $clog2(TAPS);

	// Field and datapath widths
	localparam int SAMPLE_W = 22;
	localparam int SLOPE_W  = 21;
	localparam int WEIGHT_W = 11;
	localparam int PROD_W   = SAMPLE_W + WEIGHT_W;
	localparam int ACC_W    = 36;
	localparam int SLOPE_SHIFT = 14;

	// Truncating divide by 100 via reciprocal: q = (|x| * ceil(2^28/100)) >> 28
	localparam int RECIP_W     = 22;
	localparam int QPROD_W     = SAMPLE_W + RECIP_W;
	localparam int RECIP_SHIFT = 28;
	localparam logic [RECIP_W-1:0] RECIP_100 = 22'd2684355;
	localparam int QUOT_W      = 16;

	// Slope clamp limits
	localparam logic signed [SLOPE_W-1:0] SLOPE_MAX = {1'b0, {(SLOPE_W-1){1'b1}}};
	localparam logic signed [SLOPE_W-1:0] SLOPE_MIN = {1'b1, {(SLOPE_W-1){1'b0}}};

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_DONE
	} seq_state_t;

	// Control from the sequencer to the MAC datapath
	typedef struct packed {
		logic                 clear;
		logic                 tap_vld;
		logic [TAP_IDX_W-1:0] tap_idx;
	} dp_ctrl_t;

	// Antisymmetric tap weights, newest sample first
	function automatic logic signed [WEIGHT_W-1:0] tap_weight(input logic [TAP_IDX_W-1:0] idx);
		logic signed [WEIGHT_W-1:0] w;
		case (idx)
			4'd0:    w = 11'sd1;
			4'd1:    w = 11'sd13;
			4'd2:    w = 11'sd77;
			4'd3:    w = 11'sd273;
			4'd4:    w = 11'sd637;
			4'd5:    w = 11'sd1001;
			4'd6:    w = 11'sd1001;
			4'd7:    w = 11'sd429;
			4'd8:    w = -11'sd429;
			4'd9:    w = -11'sd1001;
			4'd10:   w = -11'sd1001;
			4'd11:   w = -11'sd637;
			4'd12:   w = -11'sd273;
			4'd13:   w = -11'sd77;
			4'd14:   w = -11'sd13;
			4'd15:   w = -11'sd1;
			default: w = '0;
		endcase
		return w;
	endfunction

endpackage

### hw/rtl/dcfst_ring_mem.sv
// Sample history memory: one 16-entry ring per channel, one write and one read port.
// Per-entry valid bits make unwritten entries read as zero. Uses dcfst_pkg.
module dcfst_ring_mem #(
	parameter int CHANNELS = dcfst_pkg::CHANNELS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      we,
	input  logic [$clog2(CHANNELS*dcfst_pkg::TAPS)-1:0] waddr,
	input  logic signed [dcfst_pkg::SAMPLE_W-1:0]     wdata,
	input  logic                                      re,
	input  logic [$clog2(CHANNELS*dcfst_pkg::TAPS)-1:0] raddr,
	output logic signed [dcfst_pkg::SAMPLE_W-1:0]     rdata
);

	localparam int DEPTH = CHANNELS * dcfst_pkg::TAPS;

	logic signed [dcfst_pkg::SAMPLE_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]                      vld_q;
	logic signed [dcfst_pkg::SAMPLE_W-1:0] rd_data_q;
	logic                                  rd_vld_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_data_q <= mem[raddr];
		end
	end

	// Track written entries; hold the valid flag of the last read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (re) begin
				rd_vld_q <= vld_q[raddr];
			end
		end
	end

	// Unwritten entries read as the reset value, zero
	assign rdata = rd_vld_q ? rd_data_q : '0;

endmodule

### hw/rtl/dcfst_fir_dp.sv
// MAC datapath: weights each read sample, accumulates, clamps the slope and
// forms the divide-by-100 change flag from the two newest samples. Uses dcfst_pkg.
module dcfst_fir_dp (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  dcfst_pkg::dp_ctrl_t                    ctrl,
	input  logic signed [dcfst_pkg::SAMPLE_W-1:0]  rdata,
	output logic                                   busy,
	output logic signed [dcfst_pkg::SLOPE_W-1:0]   slope,
	output logic                                   temp_chg
);

	localparam int ACC_W   = dcfst_pkg::ACC_W;
	localparam int PROD_W  = dcfst_pkg::PROD_W;
	localparam int QPROD_W = dcfst_pkg::QPROD_W;
	localparam int QUOT_W  = dcfst_pkg::QUOT_W;

	logic                                v_s1;
	logic [dcfst_pkg::TAP_IDX_W-1:0]     idx_s1;
	logic                                v_s2;
	logic [dcfst_pkg::TAP_IDX_W-1:0]     idx_s2;
	logic signed [PROD_W-1:0]            prod_s2;
	logic [QPROD_W-1:0]                  qprod_s2;
	logic                                neg_s2;
	logic signed [ACC_W-1:0]             acc_q;
	logic signed [QUOT_W-1:0]            q_new_q;
	logic signed [QUOT_W-1:0]            q_prev_q;

	logic signed [dcfst_pkg::WEIGHT_W-1:0] weight;
	logic [dcfst_pkg::SAMPLE_W-1:0]        mag;
	logic [QUOT_W-2:0]                     qmag;
	logic signed [QUOT_W-1:0]              quot;
	logic signed [ACC_W-1:0]               shifted;

	// Weight and magnitude of the sample now on the read port
	always_comb begin
		weight = dcfst_pkg::tap_weight(idx_s1);
		mag    = rdata[dcfst_pkg::SAMPLE_W-1] ? (~rdata + 1'b1) : rdata;
	end

	// Align control with read data, then multiply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= ctrl.tap_vld;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1   <= ctrl.tap_idx;
		idx_s2   <= idx_s1;
		prod_s2  <= PROD_W'(rdata) * PROD_W'(weight);
		qprod_s2 <= QPROD_W'(mag) * QPROD_W'(dcfst_pkg::RECIP_100);
		neg_s2   <= rdata[dcfst_pkg::SAMPLE_W-1];
	end

	// Truncated quotient with the sample's sign restored
	always_comb begin
		qmag = qprod_s2[dcfst_pkg::RECIP_SHIFT +: (QUOT_W-1)];
		quot = neg_s2 ? -signed'({1'b0, qmag}) : signed'({1'b0, qmag});
	end

	// Accumulate products; keep quotients of the newest two samples
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			q_new_q  <= '0;
			q_prev_q <= '0;
		end else if (ctrl.clear) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
			if (idx_s2 == dcfst_pkg::TAP_IDX_W'(0)) begin
				q_new_q <= quot;
			end
			if (idx_s2 == dcfst_pkg::TAP_IDX_W'(1)) begin
				q_prev_q <= quot;
			end
		end
	end

	// Floor shift and clamp to the slope range
	always_comb begin
		shifted = acc_q >>> dcfst_pkg::SLOPE_SHIFT;
		if (shifted > ACC_W'(dcfst_pkg::SLOPE_MAX)) begin
			slope = dcfst_pkg::SLOPE_MAX;
		end else if (shifted < ACC_W'(dcfst_pkg::SLOPE_MIN)) begin
			slope = dcfst_pkg::SLOPE_MIN;
		end else begin
			slope = shifted[dcfst_pkg::SLOPE_W-1:0];
		end
	end

	assign busy     = v_s1 | v_s2;
	assign temp_chg = q_new_q != q_prev_q;

endmodule

### hw/rtl/dual_channel_fir_slope_tracker.sv
// Two-channel 16-tap FIR slope tracker: each sample is stored in its channel's ring
// memory, then the 16 newest samples are read back one per cycle through a single
// read port and multiply-accumulated. A result turns valid after the reads, the
// pipeline drain and the result load; a new sample is taken only once the last
// result is loaded, so the next sample can be taken while a finished result still
// waits in the output register.
// Rings, write pointers and previous slopes start at zero after reset. Channel
// numbers are folded modulo CHANNELS; out_channel echoes the input bit.
// Depends on dcfst_pkg, dcfst_ring_mem and dcfst_fir_dp.
module dual_channel_fir_slope_tracker #(
	parameter int CHANNELS = dcfst_pkg::CHANNELS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  channel,
	input  logic signed [dcfst_pkg::SAMPLE_W-1:0] temp_millic,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  out_channel,
	output logic signed [dcfst_pkg::SLOPE_W-1:0]  slope_deci,
	output logic                                  temp_changed,
	output logic                                  slope_changed
);

	localparam int TAP_IDX_W = dcfst_pkg::TAP_IDX_W;
	localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int AW        = $clog2(CHANNELS * dcfst_pkg::TAPS);

	dcfst_pkg::seq_state_t state_q, state_d;

	logic [CH_W-1:0]                      ch_q;
	logic                                 chan_bit_q;
	logic [TAP_IDX_W-1:0]                 base_q;
	logic [TAP_IDX_W-1:0]                 idx_q;
	logic [TAP_IDX_W-1:0]                 wp_q [CHANNELS];
	logic signed [dcfst_pkg::SLOPE_W-1:0] last_slope_q [CHANNELS];

	logic                                 out_valid_q;
	logic                                 out_channel_q;
	logic signed [dcfst_pkg::SLOPE_W-1:0] slope_q;
	logic                                 temp_changed_q;
	logic                                 slope_changed_q;

	logic                                 accept;
	logic                                 load_out;
	logic [CH_W-1:0]                      ch_sel;
	logic [TAP_IDX_W-1:0]                 wp_next;
	logic                                 mem_we;
	logic [AW-1:0]                        mem_waddr;
	logic                                 mem_re;
	logic [AW-1:0]                        mem_raddr;
	logic signed [dcfst_pkg::SAMPLE_W-1:0] mem_rdata;
	dcfst_pkg::dp_ctrl_t                  dp_ctrl;
	logic                                 dp_busy;
	logic signed [dcfst_pkg::SLOPE_W-1:0] dp_slope;
	logic                                 dp_temp_chg;

	// Fold channel and advance its write pointer
	always_comb begin
		ch_sel    = (CHANNELS == 1) ? '0 : CH_W'(channel);
		wp_next   = wp_q[ch_sel] + 1'b1;
		accept    = in_valid & in_ready;
		mem_waddr = AW'({ch_sel, wp_next});
		mem_raddr = AW'({ch_q, base_q - idx_q});
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			dcfst_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = dcfst_pkg::ST_RUN;
				end
			end
			dcfst_pkg::ST_RUN: begin
				if (idx_q == TAP_IDX_W'(dcfst_pkg::TAPS - 1)) begin
					state_d = dcfst_pkg::ST_DRAIN;
				end
			end
			dcfst_pkg::ST_DRAIN: begin
				if (!dp_busy) begin
					state_d = dcfst_pkg::ST_DONE;
				end
			end
			dcfst_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = dcfst_pkg::ST_IDLE;
				end
			end
			default: state_d = dcfst_pkg::ST_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		in_ready        = 1'b0;
		mem_re          = 1'b0;
		load_out        = 1'b0;
		dp_ctrl.clear   = 1'b0;
		dp_ctrl.tap_vld = 1'b0;
		dp_ctrl.tap_idx = idx_q;
		case (state_q)
			dcfst_pkg::ST_IDLE: begin
				in_ready      = 1'b1;
				dp_ctrl.clear = in_valid;
			end
			dcfst_pkg::ST_RUN: begin
				mem_re          = 1'b1;
				dp_ctrl.tap_vld = 1'b1;
			end
			dcfst_pkg::ST_DRAIN: begin
			end
			dcfst_pkg::ST_DONE: begin
				load_out = !out_valid_q || out_ready;
			end
			default: begin
			end
		endcase
	end

	assign mem_we = accept;

	// Sequencer registers and per-channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dcfst_pkg::ST_IDLE;
			idx_q   <= '0;
			for (int c = 0; c < CHANNELS; c++) begin
				wp_q[c]         <= '0;
				last_slope_q[c] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (accept) begin
				idx_q        <= '0;
				wp_q[ch_sel] <= wp_next;
			end else if (state_q == dcfst_pkg::ST_RUN) begin
				idx_q <= idx_q + 1'b1;
			end
			if (load_out) begin
				last_slope_q[ch_q] <= dp_slope;
			end
		end
	end

	// Hold the item's channel and newest ring position
	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q       <= ch_sel;
			chan_bit_q <= channel;
			base_q     <= wp_next;
		end
	end

	// Output register: transfer when taken, load when the result is ready
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_channel_q   <= chan_bit_q;
			slope_q         <= dp_slope;
			temp_changed_q  <= dp_temp_chg;
			slope_changed_q <= dp_slope != last_slope_q[ch_q];
		end
	end

	assign out_valid     = out_valid_q;
	assign out_channel   = out_channel_q;
	assign slope_deci    = slope_q;
	assign temp_changed  = temp_changed_q;
	assign slope_changed = slope_changed_q;

	dcfst_ring_mem #(
		.CHANNELS(CHANNELS)
	) u_ring_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (temp_millic),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	dcfst_fir_dp u_fir_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (dp_ctrl),
		.rdata   (mem_rdata),
		.busy    (dp_busy),
		.slope   (dp_slope),
		.temp_chg(dp_temp_chg)
	);

endmodule
